[src/segment_lcd_image_composer_defines.svh]
// Assertion macros shared by the segment LCD image composer RTL.
// No dependencies; include by bare file name inside a module body.
`ifndef SEGMENT_LCD_IMAGE_COMPOSER_DEFINES_SVH
`define SEGMENT_LCD_IMAGE_COMPOSER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SLIC_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define SLIC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[src/slic_pkg.sv]
// Shared types and segment map constants for the segment LCD image composer.
// No dependencies.
package slic_pkg;

   localparam int ImageLen = 10;
   localparam int BarSteps = 30;
   localparam logic [3:0] LastAddr = 4'd9;

   // Decoded display command handed from the front end to the byte emitter.
   typedef struct packed {
      logic [3:0][3:0] digit;     // digit[k] is display digit k+1
      logic [3:0]      digit_on;  // digit_on[k] draws display digit k+1
      logic [2:0]      point;
      logic            minus;
      logic            hold;
      logic [4:0]      bar;
   } slic_cmd_type;

   typedef enum logic [2:0] {
      FS_IDLE,
      FS_FOLD,
      FS_QUOT,
      FS_REM,
      FS_PUSH
   } front_state_type;

   // Glyphs 0..F, bit 0 = segment a ... bit 6 = segment g.
   localparam logic [6:0] Glyph [16] = '{
      7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07,
      7'h7F, 7'h67, 7'h77, 7'h7C, 7'h39, 7'h5E, 7'h79, 7'h71
   };

   localparam logic [3:0] BarByte [BarSteps] = '{
      4'd5, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6,
      4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8,
      4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7,
      4'd9, 4'd9, 4'd9, 4'd9, 4'd9, 4'd9, 4'd9, 4'd9
   };

   localparam logic [7:0] BarBit [BarSteps] = '{
      8'h01, 8'h10, 8'h20, 8'h40, 8'h80, 8'h04, 8'h02, 8'h01,
      8'h01, 8'h02, 8'h04, 8'h08, 8'h40, 8'h20, 8'h10,
      8'h01, 8'h02, 8'h04, 8'h08, 8'h40, 8'h20, 8'h10,
      8'h10, 8'h20, 8'h40, 8'h80, 8'h08, 8'h04, 8'h02, 8'h81
   };

   // Digits 1 and 2: a..g on bits 7,6,5,4,1,3,2.
   function automatic logic [7:0] seg_hi(input logic [6:0] g);
      seg_hi = {g[0], g[1], g[2], g[3], g[5], g[6], g[4], 1'b0};
   endfunction

   // Digits 3 and 4: a..g on bits 3,2,1,0,5,7,6.
   function automatic logic [7:0] seg_lo(input logic [6:0] g);
      seg_lo = {g[5], g[6], g[4], 1'b0, g[0], g[1], g[2], g[3]};
   endfunction

endpackage

[src/slic_front.sv]
// Request front end: takes a request, splits the value into decimal digits
// and applies leading-zero blanking. Depends on slic_pkg.
module slic_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [13:0]           req_display_value,
   input  logic                  req_show_leading_zeros,
   input  logic [2:0]            req_point_position,
   input  logic                  req_minus_on,
   input  logic                  req_hold_on,
   input  logic [4:0]            req_bar_level,
   input  logic                  q_full,
   output logic                  q_push,
   output slic_pkg::slic_cmd_type q_cmd
);
   import slic_pkg::*;

   localparam logic [13:0] Wrap     = 14'd10000;
   localparam logic [13:0] Recip1k  = 14'd8389;  // 2^23 / 1000, rounded up
   localparam logic [13:0] Recip100 = 14'd5243;  // 2^19 / 100, rounded up
   localparam logic [13:0] Recip10  = 14'd205;   // 2^11 / 10, rounded up
   localparam logic [1:0]  LastDig  = 2'd2;

   front_state_type state_ff, state_in;
   logic [1:0]       dig_ff;
   logic [13:0]      r_ff;
   logic [3:0]       q_ff;
   logic [2:0][3:0]  digits_ff;
   logic             lead_ff;
   logic [2:0]       point_ff;
   logic             minus_ff;
   logic             hold_ff;
   logic [4:0]       bar_ff;

   logic [27:0] prod;
   logic [3:0]  quot;
   logic [13:0] place;
   logic        accept;

   assign accept = start && (state_ff == FS_IDLE);

   // Quotient by reciprocal multiply; exact for the remainder ranges seen here.
   always_comb begin
      prod  = 28'd0;
      quot  = 4'd0;
      place = 14'd0;
      unique case (dig_ff)
         2'd0: begin
            prod  = 28'(r_ff) * 28'(Recip1k);
            quot  = prod[26:23];
            place = 14'd1000;
         end
         2'd1: begin
            prod  = 28'(r_ff) * 28'(Recip100);
            quot  = prod[22:19];
            place = 14'd100;
         end
         2'd2: begin
            prod  = 28'(r_ff) * 28'(Recip10);
            quot  = prod[14:11];
            place = 14'd10;
         end
         default: begin
            prod  = 28'd0;
            quot  = 4'd0;
            place = 14'd0;
         end
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FS_IDLE: if (start) state_in = FS_FOLD;
         FS_FOLD: state_in = FS_QUOT;
         FS_QUOT: state_in = FS_REM;
         FS_REM:  state_in = (dig_ff == LastDig) ? FS_PUSH : FS_QUOT;
         FS_PUSH: if (!q_full) state_in = FS_IDLE;
         default: state_in = FS_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      busy   = (state_ff != FS_IDLE);
      q_push = (state_ff == FS_PUSH) && !q_full;
   end

   // Blank leading zeros and pack the command.
   always_comb begin
      q_cmd.digit[0] = digits_ff[0];
      q_cmd.digit[1] = digits_ff[1];
      q_cmd.digit[2] = digits_ff[2];
      q_cmd.digit[3] = r_ff[3:0];
      if (!lead_ff && digits_ff[0] == 4'd0) begin
         q_cmd.digit_on = {1'b1,
                           (digits_ff[1] != 4'd0) || (digits_ff[2] != 4'd0),
                           (digits_ff[1] != 4'd0),
                           1'b0};
      end else begin
         q_cmd.digit_on = 4'b1111;
      end
      q_cmd.point = point_ff;
      q_cmd.minus = minus_ff;
      q_cmd.hold  = hold_ff;
      q_cmd.bar   = bar_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         r_ff     <= req_display_value;
         lead_ff  <= req_show_leading_zeros;
         point_ff <= req_point_position;
         minus_ff <= req_minus_on;
         hold_ff  <= req_hold_on;
         bar_ff   <= req_bar_level;
      end
      unique case (state_ff)
         FS_FOLD: begin
            if (r_ff >= Wrap) r_ff <= r_ff - Wrap;
            dig_ff <= 2'd0;
         end
         FS_QUOT: q_ff <= quot;
         FS_REM: begin
            r_ff              <= r_ff - (14'(q_ff) * place);
            digits_ff[dig_ff] <= q_ff;
            dig_ff            <= dig_ff + 2'd1;
         end
         default: begin
         end
      endcase
   end

endmodule

[src/slic_queue.sv]
// Short command queue between the front end and the byte emitter.
// Depends on slic_pkg.
module slic_queue #(
   parameter int Depth = 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  slic_pkg::slic_cmd_type push_cmd,
   output logic                  full,
   input  logic                  pop,
   output logic                  empty,
   output slic_pkg::slic_cmd_type head_cmd
);
   import slic_pkg::*;

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] CntFull = CntW'(Depth);

   slic_cmd_type    entry_ff [Depth];
   logic [PtrW-1:0] wr_ff, rd_ff;
   logic [CntW-1:0] count_ff;

   assign full     = (count_ff == CntFull);
   assign empty    = (count_ff == '0);
   assign head_cmd = entry_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ff] <= push_cmd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) wr_ff <= (wr_ff == PtrLast) ? '0 : wr_ff + PtrW'(1);
         if (pop)  rd_ff <= (rd_ff == PtrLast) ? '0 : rd_ff + PtrW'(1);
         if (push && !pop)      count_ff <= count_ff + CntW'(1);
         else if (pop && !push) count_ff <= count_ff - CntW'(1);
      end
   end

endmodule

[src/slic_back.sv]
// Byte emitter: walks RAM bytes 0..9 of the current command, one per cycle.
// Depends on slic_pkg and segment_lcd_image_composer_defines.svh.
module slic_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_empty,
   input  slic_pkg::slic_cmd_type q_head,
   output logic                  q_pop,
   output logic                  rsp_valid,
   output logic [3:0]            rsp_ram_address,
   output logic [7:0]            rsp_ram_byte,
   output logic                  rsp_last_byte
);
   import slic_pkg::*;
   `include "segment_lcd_image_composer_defines.svh"

   slic_cmd_type cmd_ff;
   logic         active_ff;
   logic [3:0]   addr_ff;
   logic         rsp_valid_ff;
   logic [3:0]   rsp_ram_address_ff;
   logic [7:0]   rsp_ram_byte_ff;
   logic         rsp_last_byte_ff;

   logic [7:0] digit_bits;
   logic [7:0] bar_bits;
   logic [7:0] byte_in;
   logic [6:0] g [4];
   logic       finishing;

   assign finishing = active_ff && (addr_ff == LastAddr);
   assign q_pop     = !q_empty && (!active_ff || finishing);

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         g[k] = cmd_ff.digit_on[k] ? Glyph[cmd_ff.digit[k]] : 7'd0;
      end
   end

   // Digit, point and annunciator bits of the current byte.
   always_comb begin
      unique case (addr_ff)
         4'd0: digit_bits = seg_lo(g[3]) | ((cmd_ff.point == 3'd4) ? 8'h10 : 8'h00);
         4'd1: digit_bits = seg_lo(g[2]) | ((cmd_ff.point == 3'd3) ? 8'h10 : 8'h00);
         4'd2: digit_bits = seg_hi(g[1]) | ((cmd_ff.point == 3'd2) ? 8'h01 : 8'h00);
         4'd3: digit_bits = seg_hi(g[0]) | ((cmd_ff.point == 3'd1) ? 8'h01 : 8'h00);
         4'd4: digit_bits = {cmd_ff.hold, cmd_ff.minus, 6'd0};
         default: digit_bits = 8'h00;
      endcase
   end

   // Bar graph: every step up to the level that lands in this byte; levels 30 and 31 light nothing.
   always_comb begin
      bar_bits = 8'h00;
      for (int j = 0; j < BarSteps; j++) begin
         if (cmd_ff.bar < 5'(BarSteps) && 5'(j) <= cmd_ff.bar && BarByte[j] == addr_ff) begin
            bar_bits = bar_bits | BarBit[j];
         end
      end
      byte_in = digit_bits | bar_bits;
   end

   always_ff @(posedge clock) begin
      if (q_pop) cmd_ff <= q_head;
      rsp_ram_address_ff <= addr_ff;
      rsp_ram_byte_ff    <= byte_in;
      rsp_last_byte_ff   <= finishing;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         addr_ff      <= 4'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= active_ff;
         if (q_pop) begin
            active_ff <= 1'b1;
            addr_ff   <= 4'd0;
         end else if (finishing) begin
            active_ff <= 1'b0;
            addr_ff   <= 4'd0;
         end else if (active_ff) begin
            addr_ff <= addr_ff + 4'd1;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ram_address = rsp_ram_address_ff;
   assign rsp_ram_byte    = rsp_ram_byte_ff;
   assign rsp_last_byte   = rsp_last_byte_ff;

   `SLIC_ASSERT_NEXT(a_bytes_in_order, clock, reset, rsp_valid_ff && !rsp_last_byte_ff, rsp_valid_ff && rsp_ram_address_ff == 4'($past(rsp_ram_address_ff) + 4'd1), "image bytes not contiguous")
   `SLIC_ASSERT_NEXT(a_image_starts_at_zero, clock, reset, rsp_valid_ff && rsp_last_byte_ff, !rsp_valid_ff || rsp_ram_address_ff == 4'd0, "new image not at byte 0")
   `SLIC_ASSERT_IMPLIES(a_pop_only_between_images, clock, reset, q_pop, !active_ff || addr_ff == LastAddr, "command taken mid-image")

endmodule

[src/segment_lcd_image_composer.sv]
// Top level of the segment LCD image composer: front end, command queue, byte emitter.
// Depends on slic_pkg, slic_front, slic_queue, slic_back.
//
//   channel  | ports                                   | beat
//   ---------+-----------------------------------------+------------------------------
//   request  | start, busy, req_*                      | start high while busy low
//   result   | rsp_valid, rsp_ram_address, rsp_ram_byte,| every cycle rsp_valid is high
//            | rsp_last_byte                           |
//
// After a request beat the front end stays busy through its states in order
// (fold mod 10000, then a multiply state and a subtract state for each of the
// upper three decimal digits, then the queue push, held while the queue is
// full); it takes a new request only once back in idle. The emitter loads each
// command from the queue into its command register and sends ten result beats,
// one per cycle; the single-byte result port bounds a steady stream.
// The queue lets the front end decode the next request while the emitter is
// still sending the previous image. Reset is synchronous and active high; it
// clears the front end state, the queue pointers and the emitter control.
// The receiver cannot stall: each result beat is shown for exactly one cycle.
module segment_lcd_image_composer #(
   parameter int QueueDepth = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [13:0] req_display_value,
   input  logic        req_show_leading_zeros,
   input  logic [2:0]  req_point_position,
   input  logic        req_minus_on,
   input  logic        req_hold_on,
   input  logic [4:0]  req_bar_level,
   output logic        rsp_valid,
   output logic [3:0]  rsp_ram_address,
   output logic [7:0]  rsp_ram_byte,
   output logic        rsp_last_byte
);
   import slic_pkg::*;

   slic_cmd_type push_cmd;
   slic_cmd_type head_cmd;
   logic         q_push, q_pop, q_full, q_empty;

   // Decode the request into digits and blanking flags.
   slic_front u_front (
      .clock                  (clock),
      .reset                  (reset),
      .start                  (start),
      .busy                   (busy),
      .req_display_value      (req_display_value),
      .req_show_leading_zeros (req_show_leading_zeros),
      .req_point_position     (req_point_position),
      .req_minus_on           (req_minus_on),
      .req_hold_on            (req_hold_on),
      .req_bar_level          (req_bar_level),
      .q_full                 (q_full),
      .q_push                 (q_push),
      .q_cmd                  (push_cmd)
   );

   // Hold decoded commands until the emitter is free.
   slic_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .empty    (q_empty),
      .head_cmd (head_cmd)
   );

   // Emit the ten RAM bytes of each command.
   slic_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_head          (head_cmd),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ram_address (rsp_ram_address),
      .rsp_ram_byte    (rsp_ram_byte),
      .rsp_last_byte   (rsp_last_byte)
   );

endmodule

[bench/segment_lcd_image_composer_test.sv]
// Self-checking bench for segment_lcd_image_composer: drives display requests
// and checks every RAM image beat. Depends only on the RTL under src/.
`timescale 1ns / 100ps

module segment_lcd_image_composer_test;

   localparam int ImageBytes = 10;
   localparam int CycleLimit = 200000;
   localparam int NumDirected = 22;
   localparam int RandomPerPhase = 50;
   localparam int DrainCycles = 40;

   typedef logic [ImageBytes-1:0][7:0] image_type;

   typedef struct packed {
      logic [13:0] value;
      logic        leading_zeros;
      logic [2:0]  point;
      logic        minus;
      logic        hold;
      logic [4:0]  bar;
   } lcd_request_type;

   // A directed row: request, whether its image is typed in, and that image.
   typedef struct packed {
      lcd_request_type request;
      logic            typed;
      image_type       image;
   } directed_row_type;

   typedef struct packed {
      logic      typed;
      image_type image;
   } table_image_type;

   typedef struct packed {
      logic [3:0] address;
      logic [7:0] data;
      logic       last;
   } ram_beat_type;

   // Seven-segment glyphs 0..9, bit 0 = segment a ... bit 6 = segment g.
   localparam logic [6:0] DigitGlyph [10] = '{
      7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h67
   };

   // Segment a..g bit positions: digits 1 and 2 share one layout, 3 and 4 another.
   localparam logic [7:0] HiSegBit [7] = '{8'h80, 8'h40, 8'h20, 8'h10, 8'h02, 8'h08, 8'h04};
   localparam logic [7:0] LoSegBit [7] = '{8'h08, 8'h04, 8'h02, 8'h01, 8'h20, 8'h80, 8'h40};

   localparam int BarRamByte [30] = '{
      5, 6, 6, 6, 6, 6, 6, 6,
      8, 8, 8, 8, 8, 8, 8,
      7, 7, 7, 7, 7, 7, 7,
      9, 9, 9, 9, 9, 9, 9, 9
   };

   localparam logic [7:0] BarRamBit [30] = '{
      8'h01, 8'h10, 8'h20, 8'h40, 8'h80, 8'h04, 8'h02, 8'h01,
      8'h01, 8'h02, 8'h04, 8'h08, 8'h40, 8'h20, 8'h10,
      8'h01, 8'h02, 8'h04, 8'h08, 8'h40, 8'h20, 8'h10,
      8'h10, 8'h20, 8'h40, 8'h80, 8'h08, 8'h04, 8'h02, 8'h81
   };

   localparam image_type NoImage = '0;

   // Directed requests. Columns: value, leading zeros, point, minus, hold, bar,
   // typed flag, image written byte 9 down to byte 0.
   localparam directed_row_type DirectedRows [NumDirected] = '{
      // zero with blanking shows a single 0; bar off at level 31
      {14'd0,     1'b0, 3'd0, 1'b0, 1'b0, 5'd31, 1'b1, 80'h00_00_00_00_00_00_00_00_00_AF},
      // full bar graph; last step lights two bits of byte 9
      {14'd0,     1'b0, 3'd0, 1'b0, 1'b0, 5'd29, 1'b1, 80'hFF_7F_7F_F7_01_00_00_00_00_AF},
      // every segment lit except the decimal points
      {14'd8888,  1'b1, 3'd0, 1'b1, 1'b1, 5'd29, 1'b1, 80'hFF_7F_7F_F7_01_C0_FE_FE_EF_EF},
      // top of the value range wraps to 6383
      {14'd16383, 1'b0, 3'd4, 1'b0, 1'b0, 5'd0,  1'b0, NoImage},
      {14'd10000, 1'b0, 3'd1, 1'b0, 1'b1, 5'd30, 1'b0, NoImage},
      {14'd9999,  1'b1, 3'd1, 1'b1, 1'b0, 5'd1,  1'b0, NoImage},
      {14'd0,     1'b1, 3'd2, 1'b0, 1'b0, 5'd7,  1'b0, NoImage},
      {14'd7,     1'b0, 3'd3, 1'b1, 1'b1, 5'd8,  1'b0, NoImage},
      {14'd70,    1'b0, 3'd5, 1'b0, 1'b0, 5'd14, 1'b0, NoImage},
      {14'd700,   1'b0, 3'd6, 1'b0, 1'b1, 5'd15, 1'b0, NoImage},
      {14'd705,   1'b0, 3'd7, 1'b1, 1'b0, 5'd21, 1'b0, NoImage},
      {14'd1005,  1'b0, 3'd2, 1'b0, 1'b0, 5'd22, 1'b0, NoImage},
      {14'd42,    1'b1, 3'd3, 1'b0, 1'b0, 5'd28, 1'b0, NoImage},
      {14'd40,    1'b0, 3'd4, 1'b1, 1'b1, 5'd2,  1'b0, NoImage},
      {14'd1234,  1'b0, 3'd1, 1'b0, 1'b0, 5'd3,  1'b0, NoImage},
      {14'd5678,  1'b1, 3'd2, 1'b1, 1'b0, 5'd4,  1'b0, NoImage},
      {14'd10009, 1'b0, 3'd0, 1'b0, 1'b1, 5'd5,  1'b0, NoImage},
      {14'd12000, 1'b0, 3'd3, 1'b0, 1'b0, 5'd6,  1'b0, NoImage},
      {14'd9,     1'b1, 3'd4, 1'b0, 1'b0, 5'd16, 1'b0, NoImage},
      {14'd300,   1'b1, 3'd0, 1'b1, 1'b1, 5'd23, 1'b0, NoImage},
      {14'd8192,  1'b0, 3'd7, 1'b0, 1'b0, 5'd27, 1'b0, NoImage},
      {14'd16000, 1'b1, 3'd5, 1'b1, 1'b1, 5'd31, 1'b0, NoImage}
   };

   // Sender idle chance, in percent, for each random phase.
   localparam int PhaseIdle [4] = '{0, 66, 21, 0};

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [13:0] req_display_value;
   logic        req_show_leading_zeros;
   logic [2:0]  req_point_position;
   logic        req_minus_on;
   logic        req_hold_on;
   logic [4:0]  req_bar_level;
   logic        rsp_valid;
   logic [3:0]  rsp_ram_address;
   logic [7:0]  rsp_ram_byte;
   logic        rsp_last_byte;

   ram_beat_type    image_beats_due[$];     // RAM bytes still owed by the block, oldest first
   table_image_type typed_image_queue[$];   // per request on the wire, in drive order
   int              mismatch_count = 0;
   int              cycle_count = 0;

   segment_lcd_image_composer dut (
      .clock                  (clock),
      .reset                  (reset),
      .start                  (start),
      .busy                   (busy),
      .req_display_value      (req_display_value),
      .req_show_leading_zeros (req_show_leading_zeros),
      .req_point_position     (req_point_position),
      .req_minus_on           (req_minus_on),
      .req_hold_on            (req_hold_on),
      .req_bar_level          (req_bar_level),
      .rsp_valid              (rsp_valid),
      .rsp_ram_address        (rsp_ram_address),
      .rsp_ram_byte           (rsp_ram_byte),
      .rsp_last_byte          (rsp_last_byte)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // Build the full LCD RAM image for one request. The image is cleared for
   // every request, so nothing carries over from the previous one.
   function automatic image_type compose_lcd_image(input lcd_request_type r);
      image_type       img;
      int unsigned     shown_value;
      logic [3:0][3:0] digit;   // digit[k] is display digit k+1
      logic [3:0]      shown;
      logic [6:0]      glyph;
      img = '0;
      shown_value = r.value % 10000;
      digit[0] = 4'(shown_value / 1000);
      digit[1] = 4'((shown_value / 100) % 10);
      digit[2] = 4'((shown_value / 10) % 10);
      digit[3] = 4'(shown_value % 10);

      // Blank leading zeros only while the thousands digit is zero; keep units.
      if (!r.leading_zeros && digit[0] == 4'd0) begin
         shown = {1'b1, (digit[1] != 4'd0) || (digit[2] != 4'd0), digit[1] != 4'd0, 1'b0};
      end else begin
         shown = 4'b1111;
      end

      // Display digit k+1 lives in RAM byte 3-k.
      for (int k = 0; k < 4; k++) begin
         if (shown[k]) begin
            glyph = DigitGlyph[digit[k]];
            for (int s = 0; s < 7; s++) begin
               if (glyph[s]) begin
                  img[3-k] = img[3-k] | ((k < 2) ? HiSegBit[s] : LoSegBit[s]);
               end
            end
         end
      end

      // Points 5 to 7 light nothing.
      if (r.point >= 3'd1 && r.point <= 3'd4) begin
         img[4-r.point] = img[4-r.point] | ((r.point <= 3'd2) ? 8'h01 : 8'h10);
      end
      if (r.minus) begin
         img[4] = img[4] | 8'h40;
      end
      if (r.hold) begin
         img[4] = img[4] | 8'h80;
      end
      // Levels 30 and 31 leave the bar graph dark.
      if (r.bar < 5'd30) begin
         for (int i = 0; i <= r.bar; i++) begin
            img[BarRamByte[i]] = img[BarRamByte[i]] | BarRamBit[i];
         end
      end
      return img;
   endfunction

   function automatic lcd_request_type random_request();
      lcd_request_type r;
      case ($urandom_range(4))
         0: r.value = 14'($urandom_range(99));
         1: r.value = 14'($urandom_range(9) * ((10 ** $urandom_range(3))));
         2: r.value = 14'($urandom_range(9999));
         3: r.value = 14'($urandom_range(16383, 10000));
         default: r.value = 14'($urandom_range(16383));
      endcase
      r.leading_zeros = 1'($urandom_range(1));
      r.point = 3'($urandom_range(7));
      r.minus = 1'($urandom_range(1));
      r.hold = 1'($urandom_range(1));
      r.bar = 5'($urandom_range(31));
      return r;
   endfunction

   // Send one request beat. Called at a falling edge; returns at a falling
   // edge with start still high, so back-to-back beats never drop start.
   task automatic drive_request(input lcd_request_type r, input logic typed,
                                input image_type img, input int idle_pct);
      int unsigned gap;
      gap = 0;
      while ($urandom_range(99) < idle_pct) begin
         gap++;
      end
      // Now and then stretch the gap so it lands on every phase of the emitter.
      if (idle_pct > 0 && $urandom_range(9) == 0) begin
         gap += $urandom_range(24);
      end
      repeat (gap) begin
         start <= 1'b0;
         @(negedge clock);
      end
      typed_image_queue.push_back({typed, img});
      start                  <= 1'b1;
      req_display_value      <= r.value;
      req_show_leading_zeros <= r.leading_zeros;
      req_point_position     <= r.point;
      req_minus_on           <= r.minus;
      req_hold_on            <= r.hold;
      req_bar_level          <= r.bar;
      // Hold the beat until the block takes it.
      do begin
         @(posedge clock);
      end while (busy !== 1'b0);
      @(negedge clock);
   endtask

   // Drop start and wait until every owed byte has come back.
   task automatic wait_drained();
      start <= 1'b0;
      do begin
         @(negedge clock);
      end while (image_beats_due.size() != 0 || typed_image_queue.size() != 0);
   endtask

   // Monitor: predict on each accepted request beat, check each result beat.
   always @(posedge clock) begin
      lcd_request_type request;
      table_image_type entry;
      image_type       img;
      ram_beat_type    due;
      if (!reset) begin
         if (rsp_valid) begin
            if (image_beats_due.size() == 0) begin
               mismatch_count++;
               $display("%0t: result beat expected none, actual address %0d byte %02h last %0b",
                        $time, rsp_ram_address, rsp_ram_byte, rsp_last_byte);
            end else begin
               due = image_beats_due.pop_front();
               if (rsp_ram_address !== due.address) begin
                  mismatch_count++;
                  $display("%0t: ram_address expected %0d actual %0d",
                           $time, due.address, rsp_ram_address);
               end
               if (rsp_ram_byte !== due.data) begin
                  mismatch_count++;
                  $display("%0t: ram_byte at address %0d expected %02h actual %02h",
                           $time, due.address, due.data, rsp_ram_byte);
               end
               if (rsp_last_byte !== due.last) begin
                  mismatch_count++;
                  $display("%0t: last_byte at address %0d expected %0b actual %0b",
                           $time, due.address, due.last, rsp_last_byte);
               end
            end
         end

         if (start && !busy) begin
            request = {req_display_value, req_show_leading_zeros, req_point_position,
                       req_minus_on, req_hold_on, req_bar_level};
            entry = typed_image_queue.pop_front();
            // Take the typed image where the table gives one, else predict it.
            img = entry.typed ? entry.image : compose_lcd_image(request);
            for (int i = 0; i < ImageBytes; i++) begin
               image_beats_due.push_back({4'(i), img[i], i == ImageBytes - 1});
            end
         end
      end
   end

   // Watchdog: end a hung run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("segment_lcd_image_composer_test: FAIL");
         $finish;
      end
   end

   // Stimulus: reset, directed table, random phases, drain, verdict.
   initial begin
      reset                  = 1'b1;
      start                  = 1'b0;
      req_display_value      = '0;
      req_show_leading_zeros = 1'b0;
      req_point_position     = '0;
      req_minus_on           = 1'b0;
      req_hold_on            = 1'b0;
      req_bar_level          = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int i = 0; i < NumDirected; i++) begin
         drive_request(DirectedRows[i].request, DirectedRows[i].typed,
                       DirectedRows[i].image, (i < NumDirected / 2) ? 0 : 50);
      end

      // Drain fully before each phase so the sender pauses on an idle block.
      for (int p = 0; p < 4; p++) begin
         wait_drained();
         for (int i = 0; i < RandomPerPhase; i++) begin
            drive_request(random_request(), 1'b0, NoImage, PhaseIdle[p]);
         end
      end

      wait_drained();
      // Let any stray beats show up before the verdict.
      repeat (DrainCycles) @(negedge clock);

      if (mismatch_count == 0 && image_beats_due.size() == 0) begin
         $display("segment_lcd_image_composer_test: PASS");
      end else begin
         $display("segment_lcd_image_composer_test: FAIL");
      end
      $finish;
   end

endmodule
